// ===== hdl/hpq_pkg.sv =====
// Shared package for the max-heap priority queue.
// Holds sizes, the entry layout, operation codes and status codes.
// No dependencies.
`default_nettype none

package hpq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDXX_W   = ADDR_W + 2;

   typedef struct packed {
      logic [15:0]        id;
      logic signed [15:0] prio;
      logic [31:0]        payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // operation codes
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_XMAX    = 3'd1;
   localparam logic [2:0] OP_XMIN    = 3'd2;
   localparam logic [2:0] OP_PEEK    = 3'd3;
   localparam logic [2:0] OP_UPDATE  = 3'd4;
   localparam logic [2:0] OP_CLEAR   = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/max_heap_priority_queue.sv =====
// Top level of the max-heap priority queue: operation sequencer around one heap RAM.
// Depends on hpq_pkg and hpq_ram.
`default_nettype none

//  channel   ports                     direction  accepted when
//  request   req_valid/req_ready/req_* in         req_valid && req_ready
//  response  rsp_valid/rsp_ready/rsp_* out        rsp_valid && rsp_ready
//
//  One request at a time; every access goes through the single RAM read port.
//  Insert rises the new entry one level at a time; peek reads the root.
//  Extract max moves the last entry to the root and sinks it level by level.
//  Extract min and update scan the held entries at one per cycle,
//  then sift the changed entry up or down.
//  Reset empties the queue at once; the RAM is not cleared.
//  A new request is taken while the previous response still waits.

module max_heap_priority_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_op,
   input  logic [15:0]         req_entry_id,
   input  logic signed [15:0]  req_entry_priority,
   input  logic [31:0]         req_entry_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_out_id,
   output logic signed [15:0]  rsp_out_priority,
   output logic [31:0]         rsp_out_payload,
   output logic [6:0]          rsp_entry_count,
   output logic                rsp_queue_empty
);
   import hpq_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_SCEND  = 4'd2;
   localparam logic [3:0] S_WT0    = 4'd3;
   localparam logic [3:0] S_WTLAST = 4'd4;
   localparam logic [3:0] S_UP     = 4'd5;
   localparam logic [3:0] S_UPWT   = 4'd6;
   localparam logic [3:0] S_DN     = 4'd7;
   localparam logic [3:0] S_DNWL   = 4'd8;
   localparam logic [3:0] S_DNWR   = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   entry_type         req_ff, req_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   entry_type         cur_ff, cur_in;
   entry_type         res_ff, res_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              vld_ff, vld_in;
   logic [ADDR_W-1:0] vidx_ff, vidx_in;
   entry_type         best_ff, best_in;
   logic [ADDR_W-1:0] bidx_ff, bidx_in;
   logic              found_ff, found_in;
   logic              moved_ff, moved_in;
   logic              dn_ff, dn_in;
   entry_type         left_ff, left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_ent_ff, rsp_ent_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // RAM port
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_ent;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_ent;

   // child and parent indices
   logic [IDXX_W-1:0]  lidx, ridx, cntx;
   logic [ADDR_W-1:0]  pidx;
   logic               load_rsp;

   hpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent = entry_type'(rd_raw);
   assign lidx   = {1'b0, idx_ff, 1'b1};
   assign ridx   = lidx + IDXX_W'(1);
   assign cntx   = IDXX_W'(cnt_ff);
   assign pidx   = ADDR_W'((idx_ff - ADDR_W'(1)) >> 1);
   assign load_rsp = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      status_in = status_ff;
      scan_in   = scan_ff;
      vld_in    = vld_ff;
      vidx_in   = vidx_ff;
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      found_in  = found_ff;
      moved_in  = moved_ff;
      dn_in     = dn_ff;
      left_in   = left_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_ent    = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               req_in    = '{id: req_entry_id, prio: req_entry_priority,
                             payload: req_entry_payload};
               status_in = ST_OK;
               res_in    = '0;
               moved_in  = 1'b0;
               dn_in     = 1'b0;
               scan_in   = '0;
               vld_in    = 1'b0;
               found_in  = 1'b0;
               state_in  = S_FIN;
               unique case (req_op) inside
                  OP_INSERT: begin
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        cur_in   = '{id: req_entry_id, prio: req_entry_priority,
                                     payload: req_entry_payload};
                        idx_in   = cnt_ff[ADDR_W-1:0];
                        cnt_in   = cnt_ff + CNT_W'(1);
                        state_in = S_UP;
                     end
                  end
                  OP_XMAX, OP_PEEK: begin
                     if (cnt_ff == '0) status_in = ST_EMPTY;
                     else state_in = S_WT0;
                  end
                  OP_XMIN: begin
                     if (cnt_ff == '0) status_in = ST_EMPTY;
                     else state_in = S_SCAN;
                  end
                  OP_UPDATE: begin
                     if (cnt_ff == '0) status_in = ST_NOTFOUND;
                     else state_in = S_SCAN;
                  end
                  OP_CLEAR: cnt_in = '0;
                  default: ;
               endcase
            end
         end

         // stream every held entry through the read port
         S_SCAN: begin
            if (vld_ff) begin
               if (op_ff == OP_XMIN) begin
                  if (vidx_ff == '0 || rd_ent.prio < best_ff.prio) begin
                     best_in = rd_ent;
                     bidx_in = vidx_ff;
                  end
               end else if (!found_ff && rd_ent.id == req_ff.id) begin
                  found_in = 1'b1;
                  best_in  = rd_ent;
                  bidx_in  = vidx_ff;
               end
            end
            if (scan_ff < cnt_ff) begin
               rd_addr = scan_ff[ADDR_W-1:0];
               vld_in  = 1'b1;
               vidx_in = scan_ff[ADDR_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               vld_in = 1'b0;
               if (!vld_ff) state_in = S_SCEND;
            end
         end

         S_SCEND: begin
            if (op_ff == OP_XMIN) begin
               res_in = best_ff;
               cnt_in = cnt_ff - CNT_W'(1);
               if (CNT_W'(bidx_ff) == cnt_ff - CNT_W'(1)) begin
                  state_in = S_FIN;
               end else begin
                  rd_addr  = ADDR_W'(cnt_ff - CNT_W'(1));
                  state_in = S_WTLAST;
               end
            end else if (!found_ff) begin
               status_in = ST_NOTFOUND;
               state_in  = S_FIN;
            end else begin
               cur_in = '{id: best_ff.id, prio: req_ff.prio, payload: best_ff.payload};
               idx_in = bidx_ff;
               if (req_ff.prio > best_ff.prio) begin
                  state_in = S_UP;
               end else if (req_ff.prio < best_ff.prio) begin
                  state_in = S_DN;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = bidx_ff;
                  wr_ent   = '{id: best_ff.id, prio: req_ff.prio,
                               payload: best_ff.payload};
                  state_in = S_FIN;
               end
            end
         end

         // root is on the read data
         S_WT0: begin
            res_in = rd_ent;
            if (op_ff == OP_PEEK) begin
               state_in = S_FIN;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               rd_addr  = ADDR_W'(cnt_ff - CNT_W'(1));
               state_in = S_WTLAST;
            end
         end

         // last entry is on the read data; it fills the hole
         S_WTLAST: begin
            cur_in = rd_ent;
            if (op_ff == OP_XMAX) begin
               idx_in   = '0;
               state_in = (cnt_ff == '0) ? S_FIN : S_DN;
            end else begin
               idx_in   = bidx_ff;
               dn_in    = 1'b1;
               moved_in = 1'b0;
               state_in = S_UP;
            end
         end

         S_UP: begin
            if (idx_ff == '0) begin
               if (dn_ff && !moved_ff) begin
                  state_in = S_DN;
               end else begin
                  wr_en    = 1'b1;
                  state_in = S_FIN;
               end
            end else begin
               rd_addr  = pidx;
               state_in = S_UPWT;
            end
         end

         // parent is on the read data
         S_UPWT: begin
            if (rd_ent.prio < cur_ff.prio) begin
               wr_en    = 1'b1;
               wr_ent   = rd_ent;
               idx_in   = pidx;
               moved_in = 1'b1;
               state_in = S_UP;
            end else if (dn_ff && !moved_ff) begin
               state_in = S_DN;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end
         end

         S_DN: begin
            if (lidx >= cntx) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr  = lidx[ADDR_W-1:0];
               state_in = S_DNWL;
            end
         end

         // left child is on the read data
         S_DNWL: begin
            left_in = rd_ent;
            if (ridx < cntx) begin
               rd_addr  = ridx[ADDR_W-1:0];
               state_in = S_DNWR;
            end else if (rd_ent.prio > cur_ff.prio) begin
               wr_en    = 1'b1;
               wr_ent   = rd_ent;
               idx_in   = lidx[ADDR_W-1:0];
               state_in = S_DN;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end
         end

         // right child is on the read data; left wins ties
         S_DNWR: begin
            if (left_ff.prio > cur_ff.prio) begin
               wr_en    = 1'b1;
               state_in = S_DN;
               if (rd_ent.prio > left_ff.prio) begin
                  wr_ent = rd_ent;
                  idx_in = ridx[ADDR_W-1:0];
               end else begin
                  wr_ent = left_ff;
                  idx_in = lidx[ADDR_W-1:0];
               end
            end else if (rd_ent.prio > cur_ff.prio) begin
               wr_en    = 1'b1;
               wr_ent   = rd_ent;
               idx_in   = ridx[ADDR_W-1:0];
               state_in = S_DN;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (load_rsp) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_ent_in    = res_ff;
         rsp_status_in = status_ff;
         rsp_cnt_in    = cnt_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      scan_ff       <= scan_in;
      vld_ff        <= vld_in;
      vidx_ff       <= vidx_in;
      best_ff       <= best_in;
      bidx_ff       <= bidx_in;
      found_ff      <= found_in;
      moved_ff      <= moved_in;
      dn_ff         <= dn_in;
      left_ff       <= left_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_ent_ff.id;
   assign rsp_out_priority = rsp_ent_ff.prio;
   assign rsp_out_payload  = rsp_ent_ff.payload;
   assign rsp_entry_count  = 7'(rsp_cnt_ff);
   assign rsp_queue_empty  = (rsp_cnt_ff == '0);

endmodule

`default_nettype wire

// ===== hdl/hpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module hpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/max_heap_priority_queue_tb.sv =====
// Self-checking testbench for the max-heap priority queue.
// Predicts every response with a behavioral heap; depends on hpq_pkg and the RTL.
`default_nettype none

module max_heap_priority_queue_tb;
   import hpq_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        id;
      logic signed [15:0] prio;
      logic [31:0]        payload;
      logic [6:0]         count;
      logic               empty;
   } rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_op = OP_PEEK;
   logic [15:0]        req_entry_id = '0;
   logic signed [15:0] req_entry_priority = '0;
   logic [31:0]        req_entry_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_out_id;
   logic signed [15:0] rsp_out_priority;
   logic [31:0]        rsp_out_payload;
   logic [6:0]         rsp_entry_count;
   logic               rsp_queue_empty;

   // behavioral heap
   entry_type heap_model [CAPACITY];
   int        heap_fill;
   rsp_type   expected_rsps [$];

   int  mismatches = 0;
   int  requests_sent = 0;
   int  rsps_checked = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;
   bit  no_stall = 1'b0;
   int  gap_max = 4;

   max_heap_priority_queue dut (.*);

   always #2 clock = ~clock;

   task automatic heap_swap(input int a, input int b);
      entry_type t;
      t = heap_model[a];
      heap_model[a] = heap_model[b];
      heap_model[b] = t;
   endtask

   task automatic heap_rise(input int i);
      int up;
      while (i > 0) begin
         up = (i - 1) / 2;
         if (!(heap_model[up].prio < heap_model[i].prio)) break;
         heap_swap(i, up);
         i = up;
      end
   endtask

   task automatic heap_sink(input int i);
      int best;
      forever begin
         best = i;
         if (2*i+1 < heap_fill && heap_model[2*i+1].prio > heap_model[best].prio)
            best = 2*i+1;
         if (2*i+2 < heap_fill && heap_model[2*i+2].prio > heap_model[best].prio)
            best = 2*i+2;
         if (best == i) break;
         heap_swap(i, best);
         i = best;
      end
   endtask

   // apply one request to the model, return the response it should give
   task automatic predict_heap_op(input logic [2:0] op, input entry_type e,
                                  output rsp_type r);
      int m;
      int k;
      logic signed [15:0] old_prio;
      r = '0;
      r.status = ST_OK;
      case (op) inside
         OP_INSERT: begin
            if (heap_fill >= CAPACITY) r.status = ST_FULL;
            else begin
               heap_model[heap_fill] = e;
               heap_fill++;
               heap_rise(heap_fill - 1);
            end
         end
         OP_XMAX, OP_XMIN: begin
            if (heap_fill == 0) r.status = ST_EMPTY;
            else begin
               m = 0;
               if (op == OP_XMIN)
                  for (k = 1; k < heap_fill; k++)
                     if (heap_model[k].prio < heap_model[m].prio) m = k;
               {r.id, r.prio, r.payload} = heap_model[m];
               heap_fill--;
               heap_model[m] = heap_model[heap_fill];
               if (m < heap_fill) begin
                  if (op == OP_XMIN) heap_rise(m);
                  heap_sink(m);
               end
            end
         end
         OP_PEEK: begin
            if (heap_fill == 0) r.status = ST_EMPTY;
            else {r.id, r.prio, r.payload} = heap_model[0];
         end
         OP_UPDATE: begin
            m = -1;
            for (k = 0; k < heap_fill; k++)
               if (m < 0 && heap_model[k].id == e.id) m = k;
            if (m < 0) r.status = ST_NOTFOUND;
            else begin
               old_prio = heap_model[m].prio;
               heap_model[m].prio = e.prio;
               if (e.prio > old_prio) heap_rise(m);
               else if (e.prio < old_prio) heap_sink(m);
            end
         end
         OP_CLEAR: heap_fill = 0;
         default: ;
      endcase
      r.count = heap_fill[6:0];
      r.empty = (heap_fill == 0);
   endtask

   // send one request and queue its expected response
   task automatic send_request(input logic [2:0] op, input logic [15:0] id,
                               input logic signed [15:0] prio,
                               input logic [31:0] payload);
      rsp_type r;
      req_valid <= 1'b1;
      req_op <= op;
      req_entry_id <= id;
      req_entry_priority <= prio;
      req_entry_payload <= payload;
      do @(posedge clock); while (!req_ready);
      predict_heap_op(op, {id, prio, payload}, r);
      expected_rsps = {expected_rsps, r};
      requests_sent++;
      // random gap after one request in four on average
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
      end
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_id();
      int k;
      if (heap_fill > 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, heap_fill - 1);
         return heap_model[k].id;
      end
      return 16'($urandom_range(0, 15));
   endfunction

   // receiver stall pattern plus long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else if (no_stall) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 9) < 7);
   end

   // response checker
   always @(posedge clock) begin
      rsp_type got;
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_out_id, rsp_out_priority, rsp_out_payload,
                rsp_entry_count, rsp_queue_empty};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            rsps_checked++;
            if (got !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st=%0d id=%h pr=%0d pl=%h cnt=%0d e=%0d",
                     exp_rsp.status, exp_rsp.id, exp_rsp.prio, exp_rsp.payload,
                     exp_rsp.count, exp_rsp.empty);
                  $display("          got st=%0d id=%h pr=%0d pl=%h cnt=%0d e=%0d",
                     got.status, got.id, got.prio, got.payload, got.count,
                     got.empty);
               end
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   // empty-queue cases, updates, undefined opcodes, clear, fill to capacity, overflow, drain by both ends
   task automatic test_directed();
      int k;
      send_request(OP_XMAX, 16'h0, 16'sh0, 32'h0);
      send_request(OP_XMIN, 16'h0, 16'sh0, 32'h0);
      send_request(OP_PEEK, 16'h0, 16'sh0, 32'h0);
      send_request(OP_UPDATE, 16'h1, 16'sh5, 32'h0);
      send_request(OP_INSERT, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 16'h0000, 16'sh8000, 32'h0);
      send_request(OP_INSERT, 16'h5555, 16'sh0, 32'hA5A5_5A5A);
      send_request(OP_INSERT, 16'h5555, 16'sh0, 32'h1);
      send_request(OP_PEEK, 16'h0, 16'sh0, 32'h0);
      send_request(OP_UPDATE, 16'h5555, 16'sh7FFF, 32'h0);
      send_request(OP_UPDATE, 16'hFFFF, 16'sh8000, 32'h0);
      send_request(OP_UPDATE, 16'h1234, 16'sh1, 32'h0);
      send_request(OP_XMIN, 16'h0, 16'sh0, 32'h0);
      send_request(OP_XMAX, 16'h0, 16'sh0, 32'h0);
      send_request(3'd6, 16'h0, 16'sh0, 32'h0);
      send_request(3'd7, 16'h0, 16'sh0, 32'h0);
      send_request(OP_CLEAR, 16'h0, 16'sh0, 32'h0);
      for (k = 0; k < CAPACITY + 2; k++)
         send_request(OP_INSERT, 16'(k), 16'($urandom_range(0, 7)), $urandom);
      for (k = 0; k < CAPACITY / 2; k++)
         send_request(OP_XMIN, 16'h0, 16'sh0, 32'h0);
      while (heap_fill > 0) send_request(OP_XMAX, 16'h0, 16'sh0, 32'h0);
      send_request(OP_XMAX, 16'h0, 16'sh0, 32'h0);
      end_burst();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      int k;
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         for (k = 0; k < 40; k++)
            send_request(OP_INSERT, 16'($urandom), 16'($urandom), $urandom);
      join
      end_burst();
   endtask

   // random mix; mostly inserts and extracts, duplicate priorities common
   task automatic test_random(input int n);
      int k;
      int sel;
      logic [2:0] op;
      logic signed [15:0] prio;
      for (k = 0; k < n; k++) begin
         if (k % 500 == 250) no_stall = ~no_stall;
         gap_max = (k % 700 < 350) ? 4 : 30;
         sel = $urandom_range(0, 99);
         if (sel < 40) op = OP_INSERT;
         else if (sel < 58) op = OP_XMAX;
         else if (sel < 72) op = OP_XMIN;
         else if (sel < 80) op = OP_PEEK;
         else if (sel < 96) op = OP_UPDATE;
         else if (sel < 98) op = OP_CLEAR;
         else op = 3'($urandom_range(6, 7));
         prio = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 5) - 2);
         send_request(op, (op == OP_UPDATE) ? pick_id() : 16'($urandom), prio, $urandom);
      end
      end_burst();
   endtask

   initial begin
      heap_fill = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1800);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d responses checked, %0d mismatches",
               requests_sent, rsps_checked, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/hpq_pkg.sv
hdl/hpq_ram.sv
hdl/max_heap_priority_queue.sv
tb/max_heap_priority_queue_tb.sv
